@@ rtl/pcqd_pkg.sv @@
// Package for the paced command queue dispatcher.
// Item kinds, result codes, fixed command bytes and the train number table.
// No dependencies.
package pcqd_pkg;

  typedef enum logic [2:0] {
    KIND_TICK     = 3'd0,
    KIND_SPEED    = 3'd1,
    KIND_REVERSE  = 3'd2,
    KIND_SW_WAIT  = 3'd3,
    KIND_SW_ASYNC = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_SENT    = 2'd0,
    ST_ACCEPT  = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_SWITCH_HOLD   = 2'd0,
    REG_SOLENOID_HOLD = 2'd1,
    REG_STOP_UNIT     = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_READ,
    S_HEAD,
    S_RESULT
  } state_e;

  localparam int unsigned TRAIN_QUEUES_DEF = 6;
  localparam int unsigned QUEUE_DEPTH_DEF  = 8;
  localparam int unsigned KNOWN_TRAINS     = 6;
  localparam logic [7:0]  SINGLE_BYTE_MARK = 8'd255;
  localparam logic [7:0]  SOLENOID_OFF     = 8'd32;
  localparam logic [7:0]  REVERSE_LOW      = 8'd15;
  localparam logic [7:0]  SPEED_HIGH_BASE  = 8'd16;

  localparam logic [7:0] TRAIN_TABLE [KNOWN_TRAINS] = '{
    8'd1, 8'd24, 8'd58, 8'd74, 8'd78, 8'd79
  };

  // Stored command: bytes, hold, tag flag and tag.
  typedef struct packed {
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [15:0] delay;
    logic        tag_valid;
    logic [7:0]  tag;
  } entry_t;

endpackage

@@ rtl/paced_command_queue_dispatcher.sv @@
// Paced command dispatcher: per-train command FIFOs plus one switch FIFO.
// Queue entries live in one synchronous memory; uses pcqd_pkg.
//
// An enqueue item (set speed, reverse, switch) returns one status item. It holds the
// input through accept and check steps when rejected, and through accept, check, one
// write per command (1 to 3 commands) and status when accepted, plus any wait of the
// status item on the receiver. A tick item walks every queue in order, each queue
// starting from the full elapsed count: it is accepted, then each queue's head is read,
// each retired entry takes a read step and a head step, a queue whose head stays held
// takes a head step, and each command sent is emitted after the command sent before it
// is released, plus any receiver stalls. The command memory has a single read and a
// single write port. A tick result is held back until the walk shows whether another
// follows, so its last flag is known when it is presented. The next input item is taken
// once the current one is finished.
module paced_command_queue_dispatcher #(
  parameter int unsigned TRAIN_QUEUES = pcqd_pkg::TRAIN_QUEUES_DEF,
  parameter int unsigned QUEUE_DEPTH  = pcqd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // kind[2:0], elapsed[10:3], target_id[18:11], value[26:19], requester_tag[34:27]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], first_byte[9:2], second_byte[17:10], release_valid[18],
  // release_tag[26:19]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import pcqd_pkg::*;

  localparam int unsigned NQ  = TRAIN_QUEUES + 1;
  localparam int unsigned QW  = $clog2(NQ);
  localparam int unsigned PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW  = (TRAIN_QUEUES > 1) ? $clog2(TRAIN_QUEUES) : 1;
  localparam int unsigned AW  = QW + PW;
  localparam int unsigned MEM_DEPTH = NQ << PW;
  localparam logic [QW-1:0] SWQ = QW'(TRAIN_QUEUES);

  // Command memory, one row of 2**PW entries per queue.
  entry_t mem_q [MEM_DEPTH];
  entry_t rd_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  // Queue bookkeeping in flip-flops.
  logic [PW-1:0] head_q  [NQ];
  logic [CW-1:0] count_q [NQ];
  logic [NQ-1:0] sent_q;
  logic [7:0]    speed_q [TRAIN_QUEUES];
  logic [15:0]   sw_hold_q, sol_hold_q;
  logic [9:0]    unit_q;

  state_e        state_q, state_d;
  logic [2:0]    kind_q;
  logic [7:0]    dt_q, tgt_q, val_q, tag_q;
  logic [15:0]   rem_q, rem_d;
  logic [QW-1:0] qi_q, qi_d;
  logic [1:0]    pn_q, pn_d;       // pushes remaining
  logic [1:0]    pi_q, pi_d;       // push step
  logic [7:0]    s_q;              // train speed captured for reverse
  logic [15:0]   hold_q;
  logic          out_v_q, out_last_q, pend_q;
  logic [26:0]   out_q;

  // Decode train number.
  logic          t_hit;
  logic [TW-1:0] t_idx;
  always_comb begin
    t_hit = 1'b0;
    t_idx = '0;
    for (int i = 0; i < KNOWN_TRAINS; i++) begin
      if (i < TRAIN_QUEUES && !t_hit && TRAIN_TABLE[i] == tgt_q) begin
        t_hit = 1'b1;
        t_idx = TW'(i);
      end
    end
  end

  logic [QW-1:0] tq;
  assign tq = (kind_q == KIND_SW_WAIT || kind_q == KIND_SW_ASYNC) ? SWQ : QW'(t_idx);

  // Tail slot: head plus count, wrapped at the queue depth.
  logic [CW:0]   slot_sum;
  logic [PW-1:0] slot;
  logic [PW-1:0] rpos;
  assign slot_sum = (CW+1)'(head_q[tq]) + (CW+1)'(count_q[tq]);
  assign slot = (slot_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                PW'(slot_sum - (CW+1)'(QUEUE_DEPTH)) : PW'(slot_sum);
  assign rpos = head_q[qi_q];

  // Output slot is free when empty or when its item leaves at this edge.
  logic          out_free;
  assign out_free = !out_v_q || (!pend_q && m_axis_tready);

  // Shared control decisions.
  logic          take, push, pop, emit_head, emit_stat, upd_delay, set_speed;
  logic          tick_done, flush_pend;
  logic [1:0]    stat;
  logic [3:0]    n_need;

  always_comb begin
    n_need = (kind_q == KIND_SPEED) ? 4'd1 : (kind_q == KIND_REVERSE) ? 4'd3 : 4'd2;
  end

  always_comb begin
    state_d    = state_q;
    qi_d       = qi_q;
    rem_d      = rem_q;
    pn_d       = pn_q;
    pi_d       = pi_q;
    take       = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    emit_head  = 1'b0;
    emit_stat  = 1'b0;
    upd_delay  = 1'b0;
    set_speed  = 1'b0;
    tick_done  = 1'b0;
    flush_pend = 1'b0;
    stat       = ST_ACCEPT;
    wdata      = '0;
    waddr      = {tq, slot};
    raddr      = {qi_q, rpos};
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          take = 1'b1;
          unique case (s_axis_tdata[2:0])
            KIND_TICK: begin
              state_d = S_READ;
              qi_d    = '0;
              rem_d   = 16'(s_axis_tdata[10:3]);
            end
            KIND_SPEED, KIND_REVERSE, KIND_SW_WAIT, KIND_SW_ASYNC: state_d = S_PUSH;
            default: state_d = S_IDLE;
          endcase
          pi_d = '0;
        end
      end
      // Check the request, then write one entry a cycle.
      S_PUSH: begin
        if (pi_q == 2'd0 && pn_q == 2'd0) begin
          if (kind_q != KIND_SW_WAIT && kind_q != KIND_SW_ASYNC && !t_hit) begin
            stat = ST_UNKNOWN;
          end else if ((CW'(QUEUE_DEPTH) - count_q[tq]) < CW'(n_need)) begin
            stat = ST_FULL;
          end
          if (stat != ST_ACCEPT) begin
            if (out_free) begin
              emit_stat = 1'b1;
              state_d   = S_IDLE;
            end
          end else begin
            pn_d = 2'(n_need);
          end
        end else begin
          push = 1'b1;
          pn_d = pn_q - 2'd1;
          pi_d = pi_q + 2'd1;
          unique case (kind_q)
            KIND_SPEED: begin
              wdata.b0  = val_q;
              wdata.b1  = tgt_q;
              set_speed = 1'b1;
            end
            KIND_REVERSE: begin
              wdata.b1 = tgt_q;
              unique case (pi_q)
                2'd0: begin
                  wdata.b0    = (s_q > REVERSE_LOW) ? SPEED_HIGH_BASE : 8'd0;
                  wdata.delay = hold_q;
                end
                2'd1: wdata.b0 = (s_q > REVERSE_LOW) ? 8'd31 : REVERSE_LOW;
                default: wdata.b0 = s_q;
              endcase
            end
            default: begin
              if (pi_q == 2'd0) begin
                wdata.b0    = val_q;
                wdata.b1    = tgt_q;
                wdata.delay = sw_hold_q;
              end else begin
                wdata.b0        = SOLENOID_OFF;
                wdata.b1        = SINGLE_BYTE_MARK;
                wdata.delay     = sol_hold_q;
                wdata.tag_valid = (kind_q == KIND_SW_WAIT);
                wdata.tag       = (kind_q == KIND_SW_WAIT) ? tag_q : 8'd0;
              end
            end
          endcase
          if (pn_q == 2'd1) begin
            state_d = S_RESULT;
          end
        end
      end
      S_RESULT: begin
        if (out_free) begin
          emit_stat = 1'b1;
          state_d   = S_IDLE;
        end
      end
      // Tick walk: read the head of queue qi; each queue starts with the full count.
      S_READ: begin
        if (count_q[qi_q] == '0) begin
          if (qi_q == SWQ) begin
            tick_done = 1'b1;
            state_d   = S_IDLE;
          end else begin
            qi_d  = qi_q + QW'(1);
            rem_d = 16'(dt_q);
          end
        end else begin
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        waddr = {qi_q, rpos};
        if (!sent_q[qi_q]) begin
          // Release the held result first, then send this head.
          if (pend_q) begin
            flush_pend = 1'b1;
          end else if (out_free) begin
            emit_head = 1'b1;
          end
        end else if (rd_q.delay <= rem_q) begin
          rem_d   = rem_q - rd_q.delay;
          pop     = 1'b1;
          state_d = S_READ;
        end else begin
          upd_delay = 1'b1;
          wdata     = rd_q;
          wdata.delay = rd_q.delay - rem_q;
          state_d   = S_READ;
          if (qi_q == SWQ) begin
            tick_done = 1'b1;
            state_d   = S_IDLE;
          end else begin
            qi_d  = qi_q + QW'(1);
            rem_d = 16'(dt_q);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign we = push || upd_delay;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      qi_q       <= '0;
      rem_q      <= '0;
      pn_q       <= '0;
      pi_q       <= '0;
      sent_q     <= '0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      pend_q     <= 1'b0;
      sw_hold_q  <= 16'd20;
      sol_hold_q <= 16'd15;
      unit_q     <= 10'd100;
      for (int i = 0; i < NQ; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
      for (int i = 0; i < TRAIN_QUEUES; i++) begin
        speed_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      qi_q    <= qi_d;
      rem_q   <= rem_d;
      pn_q    <= pn_d;
      pi_q    <= pi_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_SWITCH_HOLD:   sol_hold_q <= sol_hold_q;
          default: ;
        endcase
        case (cfg_index_i)
          REG_SWITCH_HOLD:   sw_hold_q  <= cfg_data_i;
          REG_SOLENOID_HOLD: sol_hold_q <= cfg_data_i;
          REG_STOP_UNIT:     unit_q     <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (push) begin
        count_q[tq] <= count_q[tq] + CW'(1);
      end
      if (set_speed) begin
        speed_q[t_idx] <= val_q;
      end
      if (emit_head) begin
        sent_q[qi_q] <= 1'b1;
      end
      if (pop) begin
        head_q[qi_q]  <= (head_q[qi_q] == PW'(QUEUE_DEPTH - 1)) ? '0 :
                         head_q[qi_q] + PW'(1);
        count_q[qi_q] <= count_q[qi_q] - CW'(1);
        sent_q[qi_q]  <= 1'b0;
      end
      // Output register; a tick result stays held until the walk shows
      // whether another result follows it.
      if (emit_head || emit_stat) begin
        out_v_q    <= 1'b1;
        out_last_q <= emit_stat;
        pend_q     <= emit_head;
      end else if (pend_q) begin
        if (tick_done || flush_pend) begin
          pend_q     <= 1'b0;
          out_last_q <= tick_done;
        end
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Item fields and output payload.
  logic [7:0] sp_sel;
  assign sp_sel = speed_q[t_idx];

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q <= s_axis_tdata[2:0];
      dt_q   <= s_axis_tdata[10:3];
      tgt_q  <= s_axis_tdata[18:11];
      val_q  <= s_axis_tdata[26:19];
      tag_q  <= s_axis_tdata[34:27];
    end
    if (state_q == S_PUSH && pi_q == 2'd0 && pn_q == 2'd0) begin
      s_q    <= sp_sel;
      hold_q <= 16'((6'(sp_sel[3:2]) + 6'd2) * 16'(unit_q));
    end
    if (emit_stat) begin
      out_q <= {19'd0, stat};
    end else if (emit_head) begin
      out_q <= {rd_q.tag_valid ? rd_q.tag : 8'd0, rd_q.tag_valid, rd_q.b1, rd_q.b0,
                ST_SENT};
    end
  end

  assign m_axis_tvalid = out_v_q && !pend_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {5'd0, out_q};

  property p_enq_one_result;
    @(posedge clk_i) disable iff (!rst_ni)
      emit_stat |-> !emit_head;
  endproperty
  assert property (p_enq_one_result) else $error("status and command emitted together");

  property p_no_overflow;
    @(posedge clk_i) disable iff (!rst_ni)
      push |-> count_q[tq] < CW'(QUEUE_DEPTH);
  endproperty
  assert property (p_no_overflow) else $error("push into a full queue");

  property p_pop_nonempty;
    @(posedge clk_i) disable iff (!rst_ni)
      pop |-> count_q[qi_q] != '0 && sent_q[qi_q];
  endproperty
  assert property (p_pop_nonempty) else $error("pop of empty or unsent head");

  property p_out_stable;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast);
  endproperty
  assert property (p_out_stable) else $error("result changed while waiting");

endmodule
